// File: hw/rtl/eos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eos_pkg;

   localparam int ACC_WORD_BITS = 32;
   localparam int ACC_WORDS     = 128;
   localparam int ACC_AW        = 7;
   localparam int MANT_BITS     = 53;
   localparam int PROD_BITS     = 160;
   localparam int STOP_SHIFT    = 162;
   localparam int EXP_W         = 13;
   localparam int NUM_TERMS     = 6;

   localparam logic [1:0] OP_GENERAL = 2'd0;

   localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
   localparam logic signed [1:0] SIGN_POS  = 2'sb01;
   localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

   localparam logic [63:0] DOUBLE_ONE = 64'h3FF0_0000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_M1_GO,
      ST_M1_WAIT,
      ST_M2_GO,
      ST_M2_WAIT,
      ST_PICK,
      ST_PASS,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_EXT
   } src_sel_type;

   typedef struct packed {
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] z;
      logic       flip;
   } term_sel_type;

   // component order: a=0..2, b=3..5, c=6..8
   function automatic term_sel_type term_sel(input logic [2:0] t);
      term_sel_type s;
      case (t)
         3'd0:    s = '{4'd0, 4'd4, 4'd8, 1'b0};
         3'd1:    s = '{4'd0, 4'd5, 4'd7, 1'b1};
         3'd2:    s = '{4'd1, 4'd5, 4'd6, 1'b0};
         3'd3:    s = '{4'd1, 4'd3, 4'd8, 1'b1};
         3'd4:    s = '{4'd2, 4'd3, 4'd7, 1'b0};
         3'd5:    s = '{4'd2, 4'd4, 4'd6, 1'b1};
         default: s = '{4'd0, 4'd4, 4'd8, 1'b0};
      endcase
      return s;
   endfunction

   function automatic logic [MANT_BITS-1:0] unpack_mant(input logic [10:0] ef,
                                                        input logic [51:0] fr);
      return (ef == 11'd0) ? {1'b0, fr} : {1'b1, fr};
   endfunction

   function automatic logic signed [EXP_W-1:0] unpack_exp(input logic [10:0] ef);
      return (ef == 11'd0) ? -13'sd1074 : ($signed({2'b00, ef}) - 13'sd1075);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/exact_orientation_sign_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// Exact sign of det[a;b;c] for three vectors of IEEE doubles, one request at a
// time. Each nonzero triple product is two 8-step products on the shared 32x32
// limb multiplier. The products are then summed largest exponent first, one
// pass per term through a pair of 128x32 accumulator RAMs (ping-pong, one word
// per cycle); a pass writes words 0 through (total alignment shift + 163) / 32,
// words 0..5 for the first term. A request with a non-finite component skips
// the products and goes straight to the answer. The accumulator RAMs need no
// clearing: words above the live range read as sign extension. The result sits
// in an output register, so a new request is taken while it waits.
module exact_orientation_sign_3d
   import eos_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [63:0]        req_a_x,
   input  wire logic [63:0]        req_a_y,
   input  wire logic [63:0]        req_a_z,
   input  wire logic [63:0]        req_b_x,
   input  wire logic [63:0]        req_b_y,
   input  wire logic [63:0]        req_b_z,
   input  wire logic [63:0]        req_c_x,
   input  wire logic [63:0]        req_c_y,
   input  wire logic [63:0]        req_c_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [1:0]       rsp_orient_sign,
   output logic                    rsp_invalid
);

   state_type state_ff, state_in;

   // unpacked components
   logic [10:0] ef_ff [9];
   logic [51:0] fr_ff [9];
   logic        sg_ff [9];
   logic        bad_ff;

   logic [63:0] comp [9];
   logic        bad_in;

   // triple products
   logic [2:0]              tcnt_ff;
   logic [127:0]            p1_ff;
   logic [127:0]            mul_a_ff;
   logic [63:0]             mul_b_ff;
   logic [PROD_BITS-1:0]    tmag_ff [NUM_TERMS];
   logic signed [EXP_W-1:0] texp_ff [NUM_TERMS];
   logic                    tneg_ff [NUM_TERMS];
   logic [NUM_TERMS-1:0]    tlive_ff;

   term_sel_type            sel;
   logic [MANT_BITS-1:0]    mx, my, mz;
   logic                    tnz;
   logic                    mul_start;
   logic                    mul_done;
   logic [191:0]            mul_prod;

   // summation
   logic                    acc_zero_ff;
   logic                    old_neg_ff;
   logic [ACC_AW-1:0]       old_hw_ff;
   logic [ACC_AW-1:0]       new_hw_ff;
   logic [9:0]              tot_ff;
   logic [9:0]              new_tot_ff;
   logic signed [EXP_W-1:0] prev_exp_ff;
   logic                    bank_ff;
   logic [ACC_AW-1:0]       q_ff;
   logic [4:0]              r_ff;
   logic [PROD_BITS-1:0]    cur_mag_ff;
   logic                    cur_neg_ff;

   logic                    iss_ff;
   logic [ACC_AW-1:0]       k_ff;
   logic                    s2_valid_ff;
   src_sel_type             src_sel_ff;
   logic [ACC_AW-1:0]       dest_ff;
   logic [31:0]             prev_word_ff;
   logic                    carry_ff;
   logic                    nz_ff;

   logic [31:0] mem0 [ACC_WORDS];
   logic [31:0] mem1 [ACC_WORDS];
   logic [31:0] rd0_ff, rd1_ff;
   logic [ACC_AW-1:0] raddr;

   // pick
   logic                    pk_found;
   logic [2:0]              pk_idx;
   logic signed [EXP_W-1:0] pk_exp;
   logic signed [EXP_W:0]   pk_d;
   logic                    pk_stop;
   logic [10:0]             pk_tot;

   // pass datapath
   logic signed [ACC_AW:0]  src_idx;
   src_sel_type             src_sel;
   logic [31:0]             cur_word;
   logic [63:0]             sh_word;
   logic [31:0]             term_word;
   logic [32:0]             sum;
   logic                    pass_last;

   logic                    req_accept;
   logic                    rsp_valid_ff;
   logic signed [1:0]       rsp_sign_ff;
   logic                    rsp_invalid_ff;

   assign req_accept = req_valid && !req_stall;

   // operand selection at accept
   always_comb begin
      comp[0] = req_a_x;
      comp[1] = req_a_y;
      comp[2] = req_a_z;
      comp[3] = req_b_x;
      comp[4] = req_b_y;
      comp[5] = req_b_z;
      comp[6] = req_c_x;
      comp[7] = req_c_y;
      comp[8] = req_c_z;
      if (req_opcode != OP_GENERAL) begin
         comp[0] = '0;
         comp[1] = '0;
         comp[2] = '0;
         comp[req_opcode - 2'd1] = DOUBLE_ONE;
      end
      bad_in = 1'b0;
      for (int i = 0; i < 9; i++) begin
         if (comp[i][62:52] == 11'h7FF) begin
            bad_in = 1'b1;
         end
      end
   end

   always_comb begin
      sel = term_sel(tcnt_ff);
      mx  = unpack_mant(ef_ff[sel.x], fr_ff[sel.x]);
      my  = unpack_mant(ef_ff[sel.y], fr_ff[sel.y]);
      mz  = unpack_mant(ef_ff[sel.z], fr_ff[sel.z]);
      tnz = (mx != '0) && (my != '0) && (mz != '0);
   end

   eos_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // next term: largest exponent, earliest on ties
   always_comb begin
      pk_found = 1'b0;
      pk_idx   = 3'd0;
      pk_exp   = '0;
      for (int t = 0; t < NUM_TERMS; t++) begin
         if (tlive_ff[t] && (!pk_found || (texp_ff[t] > pk_exp))) begin
            pk_found = 1'b1;
            pk_idx   = 3'(t);
            pk_exp   = texp_ff[t];
         end
      end
      pk_d    = {prev_exp_ff[EXP_W-1], prev_exp_ff} - {pk_exp[EXP_W-1], pk_exp};
      pk_stop = !acc_zero_ff && (pk_d >= (EXP_W+1)'(STOP_SHIFT));
      pk_tot  = {1'b0, tot_ff} + {3'b000, pk_d[7:0]};
   end

   // pass, issue stage
   always_comb begin
      src_idx = $signed({1'b0, k_ff}) - $signed({1'b0, q_ff});
      raddr   = src_idx[ACC_AW-1:0];
      if (acc_zero_ff || src_idx[ACC_AW]) begin
         src_sel = SRC_ZERO;
      end else if (src_idx[ACC_AW-1:0] > old_hw_ff) begin
         src_sel = SRC_EXT;
      end else begin
         src_sel = SRC_MEM;
      end
   end

   // pass, add stage
   always_comb begin
      case (src_sel_ff)
         SRC_MEM:  cur_word = bank_ff ? rd1_ff : rd0_ff;
         SRC_EXT:  cur_word = {32{old_neg_ff}};
         default:  cur_word = '0;
      endcase
      sh_word = {cur_word, prev_word_ff} << r_ff;
      if (dest_ff < ACC_AW'(PROD_BITS / ACC_WORD_BITS)) begin
         term_word = cur_mag_ff[{dest_ff[2:0], 5'b00000} +: 32];
      end else begin
         term_word = '0;
      end
      term_word = term_word ^ {32{cur_neg_ff}};
      sum       = {1'b0, sh_word[63:32]} + {1'b0, term_word} + {32'd0, carry_ff};
      pass_last = s2_valid_ff && (dest_ff == new_hw_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = bad_in ? ST_DONE : ST_M1_GO;
            end
         end
         ST_M1_GO: begin
            if (tnz) begin
               state_in = ST_M1_WAIT;
            end else if (tcnt_ff == 3'(NUM_TERMS - 1)) begin
               state_in = ST_PICK;
            end
         end
         ST_M1_WAIT: begin
            if (mul_done) begin
               state_in = ST_M2_GO;
            end
         end
         ST_M2_GO: state_in = ST_M2_WAIT;
         ST_M2_WAIT: begin
            if (mul_done) begin
               state_in = (tcnt_ff == 3'(NUM_TERMS - 1)) ? ST_PICK : ST_M1_GO;
            end
         end
         ST_PICK: begin
            if (!pk_found || pk_stop) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (pass_last) begin
               state_in = ST_PICK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mul_start = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_M1_GO: mul_start = tnz;
         ST_M2_GO: mul_start = 1'b1;
         default: begin
            req_stall = 1'b1;
            mul_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= 1'b0;
         s2_valid_ff  <= 1'b0;
         tlive_ff     <= '0;
         acc_zero_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  tlive_ff    <= '0;
                  acc_zero_ff <= 1'b1;
               end
            end
            ST_M2_WAIT: begin
               if (mul_done) begin
                  tlive_ff[tcnt_ff] <= 1'b1;
               end
            end
            ST_PICK: begin
               if (pk_found && !pk_stop) begin
                  tlive_ff[pk_idx] <= 1'b0;
                  iss_ff           <= 1'b1;
                  s2_valid_ff      <= 1'b0;
               end
            end
            ST_PASS: begin
               s2_valid_ff <= iss_ff;
               if (iss_ff && (k_ff == new_hw_ff)) begin
                  iss_ff <= 1'b0;
               end
               if (pass_last) begin
                  acc_zero_ff <= !(nz_ff || (sum[31:0] != '0));
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               iss_ff <= iss_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            for (int i = 0; i < 9; i++) begin
               ef_ff[i] <= comp[i][62:52];
               fr_ff[i] <= comp[i][51:0];
               sg_ff[i] <= comp[i][63];
            end
            bad_ff  <= bad_in;
            tcnt_ff <= 3'd0;
            tot_ff  <= '0;
            bank_ff <= 1'b0;
         end
         ST_M1_GO: begin
            mul_a_ff <= {75'd0, mx};
            mul_b_ff <= {11'd0, my};
            if (!tnz) begin
               tcnt_ff <= tcnt_ff + 3'd1;
            end
         end
         ST_M1_WAIT: begin
            if (mul_done) begin
               p1_ff <= mul_prod[127:0];
            end
         end
         ST_M2_GO: begin
            mul_a_ff <= p1_ff;
            mul_b_ff <= {11'd0, mz};
         end
         ST_M2_WAIT: begin
            if (mul_done) begin
               tmag_ff[tcnt_ff] <= mul_prod[PROD_BITS-1:0];
               texp_ff[tcnt_ff] <= unpack_exp(ef_ff[sel.x]) + unpack_exp(ef_ff[sel.y])
                                   + unpack_exp(ef_ff[sel.z]);
               tneg_ff[tcnt_ff] <= sg_ff[sel.x] ^ sg_ff[sel.y] ^ sg_ff[sel.z] ^ sel.flip;
               tcnt_ff          <= tcnt_ff + 3'd1;
            end
         end
         ST_PICK: begin
            cur_mag_ff   <= tmag_ff[pk_idx];
            cur_neg_ff   <= tneg_ff[pk_idx];
            prev_exp_ff  <= pk_exp;
            k_ff         <= '0;
            prev_word_ff <= '0;
            carry_ff     <= tneg_ff[pk_idx];
            nz_ff        <= 1'b0;
            if (acc_zero_ff) begin
               // fresh load: term alone fits in words 0..5
               q_ff       <= '0;
               r_ff       <= '0;
               new_tot_ff <= '0;
               new_hw_ff  <= ACC_AW'(PROD_BITS / ACC_WORD_BITS);
            end else begin
               q_ff       <= ACC_AW'(pk_d[7:5]);
               r_ff       <= pk_d[4:0];
               new_tot_ff <= pk_tot[9:0];
               new_hw_ff  <= ACC_AW'((pk_tot + 11'd163) >> 5);
            end
         end
         ST_PASS: begin
            if (iss_ff) begin
               src_sel_ff <= src_sel;
               dest_ff    <= k_ff;
               k_ff       <= k_ff + 1'b1;
            end
            if (s2_valid_ff) begin
               prev_word_ff <= cur_word;
               carry_ff     <= sum[32];
               nz_ff        <= nz_ff || (sum[31:0] != '0);
            end
            if (pass_last) begin
               bank_ff    <= ~bank_ff;
               old_hw_ff  <= new_hw_ff;
               old_neg_ff <= sum[31];
               tot_ff     <= new_tot_ff;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_invalid_ff <= bad_ff;
               if (bad_ff || acc_zero_ff) begin
                  rsp_sign_ff <= SIGN_ZERO;
               end else begin
                  rsp_sign_ff <= old_neg_ff ? SIGN_NEG : SIGN_POS;
               end
            end
         end
         default: begin
            tcnt_ff <= tcnt_ff;
         end
      endcase
   end

   // accumulator RAMs: read the old bank, write the new one
   always_ff @(posedge clock) begin
      rd0_ff <= mem0[raddr];
      rd1_ff <= mem1[raddr];
      if (state_ff == ST_PASS && s2_valid_ff) begin
         if (bank_ff) begin
            mem0[dest_ff] <= sum[31:0];
         end else begin
            mem1[dest_ff] <= sum[31:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_orient_sign = rsp_sign_ff;
   assign rsp_invalid     = rsp_invalid_ff;

endmodule
`default_nettype wire

// File: hw/rtl/eos_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module eos_mul
   import eos_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [127:0] a,
   input  wire logic [63:0]  b,
   output logic              done,
   output logic [191:0]      prod
);

   // 4x2 limb product, one 32x32 multiply per cycle, accumulated the cycle after
   logic        busy_ff;
   logic [2:0]  step_ff;
   logic        pp_valid_ff;
   logic        pp_last_ff;
   logic [2:0]  pp_pos_ff;
   logic [63:0] pp_ff;
   logic [191:0] acc_ff;
   logic        done_ff;

   logic [31:0] a_limb;
   logic [31:0] b_limb;

   assign a_limb = a[{step_ff[2:1], 5'b00000} +: 32];
   assign b_limb = b[{step_ff[0], 5'b00000} +: 32];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= 3'd0;
         pp_valid_ff <= 1'b0;
         pp_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         done_ff     <= pp_valid_ff & pp_last_ff;
         pp_valid_ff <= busy_ff;
         pp_last_ff  <= busy_ff && (step_ff == 3'd7);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pp_ff     <= a_limb * b_limb;
      pp_pos_ff <= {1'b0, step_ff[2:1]} + {2'b00, step_ff[0]};
      if (start) begin
         acc_ff <= '0;
      end else if (pp_valid_ff) begin
         acc_ff <= acc_ff + ({128'd0, pp_ff} << {pp_pos_ff, 5'b00000});
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// File: test/tb_exact_orientation_sign_3d.sv
`timescale 1ns / 1ps
module tb_exact_orientation_sign_3d;
   import eos_pkg::*;

   localparam int SUM_W      = 6400;   // exact sum span for all finite terms
   localparam int EXP_BIAS   = 3222;   // lifts the lowest product exponent to 0
   localparam int CYCLE_CAP  = 4_000_000;
   localparam int NUM_RANDOM = 650;
   localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0001;
   localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] MAX_FIN = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_SUB = 64'h0000_0000_0000_0001;
   localparam logic [63:0] MAX_SUB = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [63:0] D_ZERO  = 64'h0;
   localparam logic [63:0] D_MONE  = 64'hBFF0_0000_0000_0000;
   localparam logic [1:0]  OP_AXIS_X = 2'd1;
   localparam logic [1:0]  OP_AXIS_Y = 2'd2;
   localparam logic [1:0]  OP_AXIS_Z = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] v[9];
   } orient_req_t;

   typedef struct {
      logic signed [1:0] sgn;
      logic              inv;
   } orient_rsp_t;

   typedef struct {
      orient_req_t       r;
      bit                typed;
      logic signed [1:0] sgn;
      logic              inv;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_opcode = '0;
   logic [63:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic [63:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic [63:0] req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [1:0] rsp_orient_sign;
   logic rsp_invalid;

   orient_rsp_t pending_signs[$];
   dir_row_t    dir_rows[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int cycles = 0;
   int n_pos = 0, n_neg = 0, n_zero = 0, n_inv = 0, n_sent = 0;

   const int term_x[6]    = '{0, 0, 1, 1, 2, 2};
   const int term_y[6]    = '{4, 5, 5, 3, 3, 4};
   const int term_z[6]    = '{8, 7, 6, 8, 7, 6};
   const bit term_flip[6] = '{0, 1, 0, 1, 0, 1};

   exact_orientation_sign_3d u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_c_z(req_c_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_orient_sign(rsp_orient_sign), .rsp_invalid(rsp_invalid)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // exact determinant sign: every product lands unrounded in one wide sum
   function automatic orient_rsp_t det_sign(input orient_req_t r);
      logic [63:0] comp[9];
      logic [52:0] mant[9];
      int ex[9];
      bit neg[9];
      logic [159:0] prod;
      logic signed [SUM_W-1:0] total, term;
      orient_rsp_t res;
      bit bad;
      int x, y, z;
      bad = 0;
      total = '0;
      comp = r.v;
      if (r.op != OP_GENERAL) begin
         comp[0] = D_ZERO; comp[1] = D_ZERO; comp[2] = D_ZERO;
         comp[r.op - 1] = DOUBLE_ONE;
      end
      for (int i = 0; i < 9; i++) begin
         neg[i] = comp[i][63];
         if (comp[i][62:52] == 11'h7FF) bad = 1;
         if (comp[i][62:52] == 11'd0) begin
            mant[i] = {1'b0, comp[i][51:0]};
            ex[i] = -1074;
         end else begin
            mant[i] = {1'b1, comp[i][51:0]};
            ex[i] = int'(comp[i][62:52]) - 1075;
         end
      end
      if (bad) begin
         res.sgn = SIGN_ZERO;
         res.inv = 1'b1;
         return res;
      end
      for (int t = 0; t < 6; t++) begin
         x = term_x[t]; y = term_y[t]; z = term_z[t];
         prod = {107'b0, mant[x]} * mant[y] * mant[z];
         term = '0;
         term[159:0] = prod;
         term = term << (ex[x] + ex[y] + ex[z] + EXP_BIAS);
         if (neg[x] ^ neg[y] ^ neg[z] ^ term_flip[t]) total = total - term;
         else total = total + term;
      end
      res.inv = 1'b0;
      if (total < 0) res.sgn = SIGN_NEG;
      else if (total == 0) res.sgn = SIGN_ZERO;
      else res.sgn = SIGN_POS;
      return res;
   endfunction

   function automatic logic [63:0] small_int(input int span);
      return $realtobits(real'($signed($urandom_range(0, 2 * span)) - span));
   endfunction

   function automatic logic [63:0] rand_double();
      logic [63:0] d;
      d = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: d[62:52] = 11'd0;                                  // subnormal
         1: d[62:52] = 11'(1023 + $urandom_range(0, 60) - 30);
         2: d[51:0] = {3'($urandom_range(0, 7)), 49'd0};
         default: ;
      endcase
      return d;
   endfunction

   function automatic orient_req_t make_random();
      orient_req_t r;
      int p, q;
      r.op = ($urandom_range(0, 3) == 0) ? 2'($urandom) : OP_GENERAL;
      case ($urandom_range(0, 5))
         0: for (int i = 0; i < 9; i++) r.v[i] = small_int(4);
         1: begin
            // c in the span of a and b: determinant is zero for the general opcode
            p = $urandom_range(0, 6) - 3;
            q = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 6; i++) r.v[i] = small_int(1000);
            for (int i = 0; i < 3; i++)
               r.v[6 + i] = $realtobits(p * $bitstoreal(r.v[i]) + q * $bitstoreal(r.v[3 + i]));
         end
         2: begin
            // c a one-ulp nudge of b: tiny determinant, heavy cancellation
            for (int i = 0; i < 9; i++) r.v[i] = rand_double();
            for (int i = 0; i < 3; i++) r.v[6 + i] = r.v[3 + i];
            r.v[6 + $urandom_range(0, 2)][0] ^= 1'b1;
         end
         3: for (int i = 0; i < 9; i++) r.v[i] = {$urandom, $urandom};
         default: for (int i = 0; i < 9; i++) r.v[i] = rand_double();
      endcase
      if ($urandom_range(0, 19) == 0) begin
         case ($urandom_range(0, 5))
            0: r.v[$urandom_range(0, 8)] = POS_INF;
            1: r.v[$urandom_range(0, 8)] = {$urandom_range(0, 1) != 0, 11'h7FF, $urandom, 20'hFFFFF};
            2: r.v[$urandom_range(0, 8)] = NEG_ZERO;
            3: r.v[$urandom_range(0, 8)] = MAX_FIN;
            4: r.v[$urandom_range(0, 8)] = MIN_SUB;
            default: r.v[$urandom_range(0, 8)] = D_ZERO;
         endcase
      end
      return r;
   endfunction

   task automatic send_request(input orient_req_t r);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
         end else begin
            break;
         end
      end
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_a_x <= r.v[0]; req_a_y <= r.v[1]; req_a_z <= r.v[2];
      req_b_x <= r.v[3]; req_b_y <= r.v[4]; req_b_z <= r.v[5];
      req_c_x <= r.v[6]; req_c_y <= r.v[7]; req_c_z <= r.v[8];
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_signs.push_back(det_sign(r));
      n_sent++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      orient_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_signs.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_signs.pop_front();
            if (rsp_orient_sign !== want.sgn)
               report_mismatch("orient_sign", rsp_orient_sign, want.sgn);
            if (rsp_invalid !== want.inv)
               report_mismatch("invalid", rsp_invalid, want.inv);
            if (rsp_invalid) n_inv++;
            else if (rsp_orient_sign == SIGN_POS) n_pos++;
            else if (rsp_orient_sign == SIGN_NEG) n_neg++;
            else n_zero++;
         end
      end
   end

   task automatic add_row(input logic [1:0] op, input logic [63:0] ax, ay, az,
                          input logic [63:0] bx, by, bz, cx, cy, cz,
                          input bit typed, input logic signed [1:0] sgn,
                          input logic inv);
      dir_row_t d;
      d.r.op = op;
      d.r.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      d.typed = typed;
      d.sgn = sgn;
      d.inv = inv;
      dir_rows.push_back(d);
   endtask

   initial begin
      orient_rsp_t chk;
      logic [63:0] one;
      one = DOUBLE_ONE;
      add_row(OP_GENERAL, one, D_ZERO, D_ZERO, D_ZERO, one, D_ZERO, D_ZERO, D_ZERO, one,
              1, SIGN_POS, 0);
      add_row(OP_GENERAL, D_ZERO, one, D_ZERO, one, D_ZERO, D_ZERO, D_ZERO, D_ZERO, one,
              1, SIGN_NEG, 0);
      add_row(OP_GENERAL, D_ZERO, D_ZERO, D_ZERO, D_ZERO, D_ZERO, D_ZERO, D_ZERO, D_ZERO,
              D_ZERO, 1, SIGN_ZERO, 0);
      add_row(OP_GENERAL, NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO,
              NEG_ZERO, NEG_ZERO, NEG_ZERO, 1, SIGN_ZERO, 0);
      add_row(OP_GENERAL, one, one, one, POS_INF, one, one, one, one, one, 1, SIGN_ZERO, 1);
      add_row(OP_GENERAL, one, one, one, one, one, one, one, one, QNAN, 1, SIGN_ZERO, 1);
      add_row(OP_GENERAL, NEG_INF, D_ZERO, D_ZERO, D_ZERO, one, D_ZERO, D_ZERO, D_ZERO, one,
              1, SIGN_ZERO, 1);
      // axis opcodes ignore a, even a non-finite one
      add_row(OP_AXIS_X, QNAN, POS_INF, NEG_INF, D_ZERO, one, D_ZERO, D_ZERO, D_ZERO, one,
              1, SIGN_POS, 0);
      add_row(OP_AXIS_Y, QNAN, QNAN, QNAN, D_ZERO, one, D_ZERO, D_ZERO, D_ZERO, one,
              1, SIGN_ZERO, 0);
      add_row(OP_AXIS_Z, one, one, one, one, D_ZERO, D_ZERO, D_ZERO, one, D_ZERO,
              1, SIGN_POS, 0);
      add_row(OP_AXIS_X, one, one, one, POS_INF, one, D_ZERO, D_ZERO, D_ZERO, one,
              1, SIGN_ZERO, 1);
      add_row(OP_GENERAL, MAX_FIN, MAX_FIN, MAX_FIN, MAX_FIN, D_MONE, MAX_FIN,
              MAX_FIN, MAX_FIN, D_MONE, 0, SIGN_ZERO, 0);
      add_row(OP_GENERAL, MIN_SUB, MAX_SUB, MIN_SUB, MAX_SUB, MIN_SUB, MIN_SUB,
              MIN_SUB, MIN_SUB, MAX_SUB, 0, SIGN_ZERO, 0);
      // huge term against tiny ones: early stop region
      add_row(OP_GENERAL, MAX_FIN, MIN_SUB, MIN_SUB, MIN_SUB, MAX_FIN, MIN_SUB,
              MIN_SUB, MIN_SUB, MAX_FIN, 0, SIGN_ZERO, 0);
      add_row(OP_GENERAL, MIN_SUB, MAX_FIN, MAX_FIN, MAX_FIN, MIN_SUB, MAX_FIN,
              MAX_FIN, MAX_FIN, MIN_SUB, 0, SIGN_ZERO, 0);
      add_row(OP_GENERAL, 64'hFFEF_FFFF_FFFF_FFFF, MAX_SUB, one, MAX_SUB, MAX_FIN, D_MONE,
              one, D_MONE, 64'h8000_0000_0000_0001, 0, SIGN_ZERO, 0);
      add_row(OP_GENERAL, 64'h3FF0_0000_0000_0001, one, one, one, one, D_ZERO,
              one, D_ZERO, one, 0, SIGN_ZERO, 0);
      add_row(OP_AXIS_Z, D_ZERO, D_ZERO, D_ZERO, MAX_FIN, MIN_SUB, NEG_ZERO,
              MIN_SUB, MAX_FIN, D_ZERO, 0, SIGN_ZERO, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 71;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].typed) begin
            chk = det_sign(dir_rows[i].r);
            if (chk.sgn !== dir_rows[i].sgn || chk.inv !== dir_rows[i].inv)
               $display("directed row %0d: table and prediction disagree", i);
         end
         send_request(dir_rows[i].r);
         if (dir_rows[i].typed) begin
            pending_signs[$].sgn = dir_rows[i].sgn;
            pending_signs[$].inv = dir_rows[i].inv;
         end
      end
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 17 : 0;
         for (int k = 0; k < NUM_RANDOM / 3 + 1; k++) send_request(make_random());
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait (pending_signs.size() == 0);
      repeat (300) @(posedge clock);
      $display("%0d requests sent over three stall patterns, directed corners first", n_sent);
      $display("responses: %0d positive, %0d negative, %0d zero, %0d invalid",
               n_pos, n_neg, n_zero, n_inv);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/eos_pkg.sv
hw/rtl/eos_mul.sv
hw/rtl/exact_orientation_sign_3d.sv
test/tb_exact_orientation_sign_3d.sv
